[design/ebsm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants for the energy buffer supply monitor.
// No dependencies; imported by every module of the block.
package ebsm_pkg;

  localparam int DEF_ENERGY_BITS      = 40;
  localparam int DEF_ENERGY_FRAC_BITS = 8;

  localparam int CAP_BITS   = 24;
  localparam int VOLT_BITS  = 24;
  localparam int QUOT_BITS  = 2 * VOLT_BITS;
  localparam int SREM_BITS  = VOLT_BITS + 1;
  localparam int SUB_BITS   = SREM_BITS + 2;
  localparam int DELTA_BITS = 32;
  localparam int CMD_BITS   = 2;
  localparam int IDX_BITS   = 3;
  localparam int OUT_DATA_BITS = 32;

  localparam longint unsigned LOW_RESET  = 64'd4147200;
  localparam longint unsigned HIGH_RESET = 64'd16588800;
  localparam longint unsigned WARN_RESET = 64'd5120000;
  localparam longint unsigned CAP_RESET  = 64'd10000;

  localparam logic [VOLT_BITS-1:0] VOLT_MAX = '1;

  localparam logic [IDX_BITS-1:0] REG_LOW       = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_HIGH      = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_WARN      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_CAP       = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_UNLIMITED = 3'd4;

  localparam logic [CMD_BITS-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_REFILL = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_REBOOT = 2'd2;

  typedef enum logic [1:0] {
    MODE_ON  = 2'd0,
    MODE_INT = 2'd1,
    MODE_OFF = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_APPLY,
    S_MODE,
    S_START,
    S_VOLT,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    V_IDLE,
    V_DIV,
    V_SQRT
  } vstate_t;

  typedef struct packed {
    logic                 done;
    logic [VOLT_BITS-1:0] voltage;
  } volt_rsp_t;

endpackage

[design/ebsm_sub.sv]
`timescale 1ns / 1ps
// Shared compare-subtract unit: difference and a >= b flag.
// Used by the voltage unit for both the division and the square root.
module ebsm_sub
  import ebsm_pkg::*;
#(
  parameter int W = SUB_BITS
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] diff,
  output logic         ge
);

  logic [W:0] d;

  assign d    = {1'b0, a} - {1'b0, b};
  assign ge   = ~d[W];
  assign diff = d[W-1:0];

endmodule

[design/ebsm_volt.sv]
`timescale 1ns / 1ps
// Capacitor voltage unit: restoring division of scaled energy by capacitance,
// then a bit-pair square root, both on the shared ebsm_sub unit. Uses ebsm_pkg.
module ebsm_volt
  import ebsm_pkg::*;
#(
  parameter int ENERGY_BITS      = DEF_ENERGY_BITS,
  parameter int ENERGY_FRAC_BITS = DEF_ENERGY_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ENERGY_BITS+1:0] level,
  input  logic [CAP_BITS-1:0]           cap,
  output volt_rsp_t                     rsp
);

  localparam int LW = ENERGY_BITS + 2;
  localparam int VS = 33 - ENERGY_FRAC_BITS;
  localparam int DW = ENERGY_BITS + 1 + VS;
  localparam int CW = $clog2(DW);

  vstate_t                vstate_r, vstate_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [ENERGY_BITS:0]   e_r, e_nxt;
  logic [SREM_BITS-1:0]   rem_r, rem_nxt;
  logic [QUOT_BITS-1:0]   quot_r, quot_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [VOLT_BITS-1:0]   root_r, root_nxt;
  logic                   done_r, done_nxt;
  logic [VOLT_BITS-1:0]   volt_r, volt_nxt;

  logic [SUB_BITS-1:0]    sub_a, sub_b, sub_diff;
  logic                   sub_ge;
  logic                   nonpos;
  logic                   ovf_div;

  assign nonpos  = level[LW-1] || (level == '0);
  assign ovf_div = ovf_r | quot_r[QUOT_BITS-1];

  always_comb begin
    if (vstate_r == V_SQRT) begin
      sub_a = {rem_r, quot_r[QUOT_BITS-1 -: 2]};
      sub_b = {1'b0, root_r, 2'b01};
    end else begin
      sub_a = {{(SUB_BITS-CAP_BITS-1){1'b0}}, rem_r[CAP_BITS-1:0], e_r[ENERGY_BITS]};
      sub_b = {{(SUB_BITS-CAP_BITS){1'b0}}, cap};
    end
  end

  ebsm_sub #(.W(SUB_BITS)) u_sub (
    .a    (sub_a),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  always_comb begin
    vstate_nxt = vstate_r;
    unique case (vstate_r)
      V_IDLE: begin
        if (start && !nonpos && (cap != '0)) begin
          vstate_nxt = V_DIV;
        end
      end
      V_DIV: begin
        if (cnt_r == '0) begin
          vstate_nxt = ovf_div ? V_IDLE : V_SQRT;
        end
      end
      V_SQRT: begin
        if (cnt_r == '0) begin
          vstate_nxt = V_IDLE;
        end
      end
      default: vstate_nxt = V_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    e_nxt    = e_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    root_nxt = root_r;
    done_nxt = 1'b0;
    volt_nxt = volt_r;
    unique case (vstate_r)
      V_IDLE: begin
        if (start) begin
          if (nonpos) begin
            volt_nxt = '0;
            done_nxt = 1'b1;
          end else if (cap == '0) begin
            volt_nxt = VOLT_MAX;
            done_nxt = 1'b1;
          end else begin
            e_nxt    = level[ENERGY_BITS:0];
            rem_nxt  = '0;
            quot_nxt = '0;
            ovf_nxt  = 1'b0;
            cnt_nxt  = CW'(DW - 1);
          end
        end
      end
      V_DIV: begin
        e_nxt    = {e_r[ENERGY_BITS-1:0], 1'b0};
        rem_nxt  = sub_ge ? sub_diff[SREM_BITS-1:0] : sub_a[SREM_BITS-1:0];
        quot_nxt = {quot_r[QUOT_BITS-2:0], sub_ge};
        ovf_nxt  = ovf_div;
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (ovf_div) begin
            volt_nxt = VOLT_MAX;
            done_nxt = 1'b1;
          end else begin
            cnt_nxt  = CW'(VOLT_BITS - 1);
            rem_nxt  = '0;
            root_nxt = '0;
          end
        end
      end
      V_SQRT: begin
        rem_nxt  = sub_ge ? sub_diff[SREM_BITS-1:0] : sub_a[SREM_BITS-1:0];
        quot_nxt = {quot_r[QUOT_BITS-3:0], 2'b00};
        root_nxt = {root_r[VOLT_BITS-2:0], sub_ge};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          volt_nxt = root_nxt;
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vstate_r <= V_IDLE;
      done_r   <= 1'b0;
    end else begin
      vstate_r <= vstate_nxt;
      done_r   <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    e_r    <= e_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
    root_r <= root_nxt;
    volt_r <= volt_nxt;
  end

  assign rsp.done    = done_r;
  assign rsp.voltage = volt_r;

endmodule

[design/energy_buffer_supply_monitor.sv]
`timescale 1ns / 1ps
// Top level: stream ports, threshold registers, energy level and supply mode.
// Depends on ebsm_pkg and ebsm_volt (which uses ebsm_sub).

// Keeps a signed energy level for a storage capacitor and an on / interrupt /
// off supply mode. Each input beat (in_tuser = command, in_tdata = signed
// delta) adds energy (ignored while unlimited is set), refills to high_energy
// or forces a reboot, and yields one output beat with the new mode and
// floor(sqrt(2E/C)) in 1/65536 V. One item at a time: the result comes from
// the shared compare-subtract unit, which runs one quotient bit per cycle over
// the scaled energy and then one root bit per cycle over 24 bits. An item
// whose level is not positive, or with zero capacitance, skips the division
// and the root. The next beat is taken only once the result is posted. A
// finished result waits in the output register while the next beat is taken;
// a second finished result holds until that one drains.
// Configure thresholds while idle, then issue a refill.
module energy_buffer_supply_monitor
  import ebsm_pkg::*;
#(
  parameter int ENERGY_BITS      = DEF_ENERGY_BITS,
  parameter int ENERGY_FRAC_BITS = DEF_ENERGY_FRAC_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [DELTA_BITS-1:0]    in_tdata,   // [31:0] energy_delta
  input  logic [CMD_BITS-1:0]      in_tuser,   // [1:0] cmd
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata,  // [1:0] power_mode, [25:2] cap_voltage
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IDX_BITS-1:0]      cfg_index,
  input  logic [ENERGY_BITS-1:0]   cfg_data
);

  localparam int LW   = ENERGY_BITS + 2;
  localparam int SUMW = ((LW > DELTA_BITS + 1) ? LW : DELTA_BITS + 1) + 1;
  localparam logic [SUMW-1:0] LEVEL_MAX =
    {{(SUMW-ENERGY_BITS-1){1'b0}}, {(ENERGY_BITS+1){1'b1}}};

  state_t                 state_r, state_nxt;
  logic [CMD_BITS-1:0]    cmd_r;
  logic [DELTA_BITS-1:0]  delta_r;
  logic signed [LW-1:0]   level_r, level_nxt;
  logic signed [SUMW-1:0] sum_r, sum_nxt;
  mode_t                  mode_r, mode_nxt;
  logic                   out_valid_r, out_valid_nxt;
  mode_t                  out_mode_r, out_mode_nxt;
  logic [VOLT_BITS-1:0]   out_volt_r, out_volt_nxt;

  logic [ENERGY_BITS-1:0] low_r, high_r, warn_r;
  logic [CAP_BITS-1:0]    cap_r;
  logic                   unl_r;

  logic                   start;
  volt_rsp_t              rsp;
  logic signed [SUMW-1:0] sum_full, lo_s, hi_s, warn_s, lo_m1;
  logic                   do_add, out_free;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= ENERGY_BITS'(LOW_RESET);
      high_r <= ENERGY_BITS'(HIGH_RESET);
      warn_r <= ENERGY_BITS'(WARN_RESET);
      cap_r  <= CAP_BITS'(CAP_RESET);
      unl_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LOW:       low_r  <= cfg_data;
        REG_HIGH:      high_r <= cfg_data;
        REG_WARN:      warn_r <= cfg_data;
        REG_CAP:       cap_r  <= cfg_data[CAP_BITS-1:0];
        REG_UNLIMITED: unl_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign do_add   = (cmd_r == CMD_ADD) && !unl_r;
  assign out_free = !out_valid_r || out_tready;
  assign sum_full = {{(SUMW-LW){level_r[LW-1]}}, level_r}
                  + {{(SUMW-DELTA_BITS){delta_r[DELTA_BITS-1]}}, delta_r};
  assign lo_s     = {{(SUMW-ENERGY_BITS){1'b0}}, low_r};
  assign hi_s     = {{(SUMW-ENERGY_BITS){1'b0}}, high_r};
  assign warn_s   = {{(SUMW-ENERGY_BITS){1'b0}}, warn_r};
  assign lo_m1    = lo_s - SUMW'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_APPLY;
      S_APPLY: state_nxt = do_add ? S_MODE : S_START;
      S_MODE:  state_nxt = S_START;
      S_START: state_nxt = S_VOLT;
      S_VOLT:  if (rsp.done) state_nxt = S_FIN;
      S_FIN:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    start     = (state_r == S_START);
  end

  always_comb begin
    level_nxt     = level_r;
    sum_nxt       = sum_r;
    mode_nxt      = mode_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_mode_nxt  = out_mode_r;
    out_volt_nxt  = out_volt_r;
    unique case (state_r)
      S_APPLY: begin
        unique case (cmd_r)
          CMD_ADD: begin
            if (!unl_r) begin
              sum_nxt = (sum_full > $signed(LEVEL_MAX)) ? $signed(LEVEL_MAX) : sum_full;
            end
          end
          CMD_REFILL: begin
            level_nxt = {2'b00, high_r};
            mode_nxt  = MODE_ON;
          end
          CMD_REBOOT: mode_nxt = MODE_OFF;
          default: ;
        endcase
      end
      S_MODE: begin
        unique case (mode_r)
          MODE_ON: begin
            if (sum_r <= lo_s) begin
              mode_nxt = MODE_OFF;
            end else if (sum_r <= warn_s) begin
              mode_nxt = MODE_INT;
            end
          end
          MODE_INT: if (sum_r <= lo_s) mode_nxt = MODE_OFF;
          MODE_OFF: if (sum_r >= hi_s) mode_nxt = MODE_ON;
          default: mode_nxt = mode_r;
        endcase
        level_nxt = (sum_r < lo_s) ? lo_m1[LW-1:0] : sum_r[LW-1:0];
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_mode_nxt  = mode_r;
          out_volt_nxt  = rsp.voltage;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= LW'(HIGH_RESET);
      mode_r      <= MODE_ON;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_tvalid && in_tready) begin
      cmd_r   <= in_tuser;
      delta_r <= in_tdata;
    end
    sum_r      <= sum_nxt;
    out_mode_r <= out_mode_nxt;
    out_volt_r <= out_volt_nxt;
  end

  ebsm_volt #(
    .ENERGY_BITS      (ENERGY_BITS),
    .ENERGY_FRAC_BITS (ENERGY_FRAC_BITS)
  ) u_volt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .level (level_r),
    .cap   (cap_r),
    .rsp   (rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-VOLT_BITS-2){1'b0}}, out_volt_r, out_mode_r};

  a_level_floor: assert property (@(posedge clk) disable iff (!rst_n)
    !level_r[LW-1] || (&level_r))
    else $error("energy level below one unit under zero");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rsp.done |-> (state_r == S_VOLT))
    else $error("voltage unit finished outside wait state");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_FIN))
    else $error("output beat raised outside finish state");

  a_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_APPLY && cmd_r == CMD_REFILL) |=>
      (mode_r == MODE_ON && level_r == {2'b00, high_r}))
    else $error("refill did not restore level and mode");

endmodule
